>>> hw/rtl/x64e_pkg.sv
`timescale 1ns / 1ps
package x64e_pkg;

  localparam int unsigned MaxBytes = 12;
  localparam int unsigned CntW     = 4;

  typedef enum logic [5:0] {
    OP_MOV_RI64  = 6'd0,  OP_MOV_RI32 = 6'd1,  OP_MOV_RR   = 6'd2,  OP_MOV_RM  = 6'd3,
    OP_MOV_MR    = 6'd4,  OP_MOV_MI   = 6'd5,  OP_ADD_RR   = 6'd6,  OP_ADD_RI  = 6'd7,
    OP_SUB_RR    = 6'd8,  OP_SUB_RI   = 6'd9,  OP_IMUL     = 6'd10, OP_IDIV    = 6'd11,
    OP_CQO       = 6'd12, OP_NEG      = 6'd13, OP_INC      = 6'd14, OP_DEC     = 6'd15,
    OP_CMP_RR    = 6'd16, OP_CMP_RI   = 6'd17, OP_CMP_MB   = 6'd18, OP_TEST    = 6'd19,
    OP_SETCC     = 6'd20, OP_MOVZX    = 6'd21, OP_JMP_REL  = 6'd22, OP_JMP_R   = 6'd23,
    OP_JCC       = 6'd24, OP_CALL_R   = 6'd25, OP_CALL_REL = 6'd26, OP_RET     = 6'd27,
    OP_PUSH      = 6'd28, OP_POP      = 6'd29, OP_AND      = 6'd30, OP_OR      = 6'd31,
    OP_XOR       = 6'd32, OP_NOT      = 6'd33, OP_LEA      = 6'd34, OP_NOP     = 6'd35
  } op_e;

  typedef struct packed {
    logic [5:0]  operation;
    logic [3:0]  first_reg;
    logic [3:0]  second_reg;
    logic [31:0] displacement;
    logic [63:0] immediate;
    logic [2:0]  condition;
  } req_t;

  typedef struct packed {
    logic [7:0]  code_byte;
    logic [31:0] byte_position;
    logic        patch_site;
    logic        last_byte;
  } res_t;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [MaxBytes-1:0]      marks;
    logic [CntW-1:0]          count;
  } seq_t;

  function automatic logic [7:0] set_code(input logic [2:0] c);
    unique case (c)
      3'd0: set_code = 8'h9C;
      3'd1: set_code = 8'h9F;
      3'd2: set_code = 8'h94;
      3'd3: set_code = 8'h95;
      3'd4: set_code = 8'h9E;
      default: set_code = 8'h9D;
    endcase
  endfunction

endpackage

>>> hw/rtl/x64e_req_if.sv
`timescale 1ns / 1ps
interface x64e_req_if;
  import x64e_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/x64e_res_if.sv
`timescale 1ns / 1ps
interface x64e_res_if;
  import x64e_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/x64e_encode.sv
`timescale 1ns / 1ps
module x64e_encode (
  input  x64e_pkg::req_t req_i,
  output x64e_pkg::seq_t seq_o
);
  import x64e_pkg::*;

  logic [MaxBytes-1:0][7:0] b;
  logic [MaxBytes-1:0]      m;
  logic [CntW-1:0]          n;
  logic [3:0]  ra, rb;
  logic [31:0] d, i32;
  logic [7:0]  rexab, rexa;
  logic        i8ok, d8ok, mz, msib;
  logic [1:0]  mmode;
  logic [7:0]  mreg_byte;
  logic [2:0]  ext;
  logic [7:0]  opc;

  always_comb begin
    ra    = req_i.first_reg;
    rb    = req_i.second_reg;
    d     = req_i.displacement;
    i32   = req_i.immediate[31:0];
    rexab = 8'h48 | {5'd0, ra[3], 1'b0, rb[3]};
    rexa  = 8'h48 | {7'd0, ra[3]};
    i8ok  = (i32[31:7] == '0) || (i32[31:7] == '1);
    d8ok  = (d[31:7] == '0) || (d[31:7] == '1);
    msib  = (rb[2:0] == 3'd4);
    mz    = (d == '0) && (rb[2:0] != 3'd5);
    mmode = mz ? 2'd0 : (d8ok ? 2'd1 : 2'd2);
    b = '0;
    m = '0;
    n = '0;
    ext = 3'd0;
    opc = 8'h00;
    mreg_byte = 8'h00;
    unique case (req_i.operation)
      OP_MOV_RI64: begin
        b[0] = rexa; b[1] = 8'hB8 + {5'd0, ra[2:0]};
        b[2] = i32[7:0]; b[3] = i32[15:8]; b[4] = i32[23:16]; b[5] = i32[31:24];
        b[6] = req_i.immediate[39:32]; b[7] = req_i.immediate[47:40];
        b[8] = req_i.immediate[55:48]; b[9] = req_i.immediate[63:56];
        n = 4'd10;
      end
      OP_MOV_RI32: begin
        b[0] = rexa; b[1] = 8'hC7; b[2] = {5'b11000, ra[2:0]};
        b[3] = i32[7:0]; b[4] = i32[15:8]; b[5] = i32[23:16]; b[6] = i32[31:24];
        n = 4'd7;
      end
      OP_MOV_RM, OP_MOV_MR, OP_LEA, OP_MOV_MI, OP_CMP_MB: begin
        unique case (req_i.operation)
          OP_MOV_RM: begin b[0] = rexab; b[1] = 8'h8B; mreg_byte = {5'd0, ra[2:0]}; n = 4'd2; end
          OP_MOV_MR: begin b[0] = rexab; b[1] = 8'h89; mreg_byte = {5'd0, ra[2:0]}; n = 4'd2; end
          OP_LEA:    begin b[0] = rexab; b[1] = 8'h8D; mreg_byte = {5'd0, ra[2:0]}; n = 4'd2; end
          OP_MOV_MI: begin
            b[0] = 8'h48 | {7'd0, rb[3]}; b[1] = 8'hC7; mreg_byte = 8'd0; n = 4'd2;
          end
          default: begin
            mreg_byte = 8'd7;
            if (rb[3]) begin b[0] = 8'h41; b[1] = 8'h80; n = 4'd2; end
            else begin b[0] = 8'h80; n = 4'd1; end
          end
        endcase
        b[n] = {mmode, mreg_byte[2:0], msib ? 3'd4 : rb[2:0]};
        n = n + 4'd1;
        if (msib) begin b[n] = 8'h24; n = n + 4'd1; end
        if (mmode == 2'd1) begin
          b[n] = d[7:0]; n = n + 4'd1;
        end else if (mmode == 2'd2) begin
          b[n] = d[7:0]; b[n+4'd1] = d[15:8]; b[n+4'd2] = d[23:16]; b[n+4'd3] = d[31:24];
          n = n + 4'd4;
        end
        if (req_i.operation == OP_MOV_MI) begin
          b[n] = i32[7:0]; b[n+4'd1] = i32[15:8]; b[n+4'd2] = i32[23:16];
          b[n+4'd3] = i32[31:24];
          n = n + 4'd4;
        end else if (req_i.operation == OP_CMP_MB) begin
          b[n] = i32[7:0]; n = n + 4'd1;
        end
      end
      OP_MOV_RR, OP_ADD_RR, OP_SUB_RR, OP_CMP_RR, OP_TEST, OP_AND, OP_OR, OP_XOR: begin
        unique case (req_i.operation)
          OP_MOV_RR: opc = 8'h89;
          OP_ADD_RR: opc = 8'h01;
          OP_SUB_RR: opc = 8'h29;
          OP_CMP_RR: opc = 8'h39;
          OP_TEST:   opc = 8'h85;
          OP_AND:    opc = 8'h21;
          OP_OR:     opc = 8'h09;
          default:   opc = 8'h31;
        endcase
        b[0] = 8'h48 | {5'd0, rb[3], 1'b0, ra[3]}; b[1] = opc;
        b[2] = {2'b11, rb[2:0], ra[2:0]};
        n = 4'd3;
      end
      OP_ADD_RI, OP_SUB_RI, OP_CMP_RI: begin
        unique case (req_i.operation)
          OP_ADD_RI: ext = 3'd0;
          OP_SUB_RI: ext = 3'd5;
          default:   ext = 3'd7;
        endcase
        b[0] = rexa; b[2] = {2'b11, ext, ra[2:0]}; b[3] = i32[7:0];
        if (i8ok) begin
          b[1] = 8'h83; n = 4'd4;
        end else begin
          b[1] = 8'h81; b[4] = i32[15:8]; b[5] = i32[23:16]; b[6] = i32[31:24]; n = 4'd7;
        end
      end
      OP_IMUL, OP_MOVZX: begin
        b[0] = rexab; b[1] = 8'h0F;
        b[2] = (req_i.operation == OP_IMUL) ? 8'hAF : 8'hB6;
        b[3] = {2'b11, ra[2:0], rb[2:0]};
        n = 4'd4;
      end
      OP_IDIV, OP_NEG, OP_INC, OP_DEC, OP_NOT: begin
        unique case (req_i.operation)
          OP_IDIV: begin opc = 8'hF7; ext = 3'd7; end
          OP_NEG:  begin opc = 8'hF7; ext = 3'd3; end
          OP_INC:  begin opc = 8'hFF; ext = 3'd0; end
          OP_DEC:  begin opc = 8'hFF; ext = 3'd1; end
          default: begin opc = 8'hF7; ext = 3'd2; end
        endcase
        b[0] = rexa; b[1] = opc; b[2] = {2'b11, ext, ra[2:0]};
        n = 4'd3;
      end
      OP_CQO: begin b[0] = 8'h48; b[1] = 8'h99; n = 4'd2; end
      OP_SETCC, OP_JMP_R, OP_CALL_R, OP_PUSH, OP_POP: begin
        if (ra[3]) begin b[0] = 8'h41; n = 4'd1; end
        unique case (req_i.operation)
          OP_SETCC: begin
            b[n] = 8'h0F; b[n+4'd1] = set_code(req_i.condition);
            b[n+4'd2] = {5'b11000, ra[2:0]}; n = n + 4'd3;
          end
          OP_JMP_R: begin
            b[n] = 8'hFF; b[n+4'd1] = {5'b11100, ra[2:0]}; n = n + 4'd2;
          end
          OP_CALL_R: begin
            b[n] = 8'hFF; b[n+4'd1] = {5'b11010, ra[2:0]}; n = n + 4'd2;
          end
          OP_PUSH: begin b[n] = 8'h50 + {5'd0, ra[2:0]}; n = n + 4'd1; end
          default: begin b[n] = 8'h58 + {5'd0, ra[2:0]}; n = n + 4'd1; end
        endcase
      end
      OP_JMP_REL: begin b[0] = 8'hE9; m[1] = 1'b1; n = 4'd5; end
      OP_CALL_REL: begin b[0] = 8'hE8; m[1] = 1'b1; n = 4'd5; end
      OP_JCC: begin
        b[0] = 8'h0F; b[1] = set_code(req_i.condition) - 8'h10; m[2] = 1'b1; n = 4'd6;
      end
      OP_RET: begin b[0] = 8'hC3; n = 4'd1; end
      OP_NOP: begin b[0] = 8'h90; n = 4'd1; end
      default: n = '0;
    endcase
    seq_o.bytes = b;
    seq_o.marks = m;
    seq_o.count = n;
  end
endmodule

>>> hw/rtl/x64e_emit.sv
`timescale 1ns / 1ps
module x64e_emit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  x64e_pkg::seq_t seq_i,
  input  logic           load_i,
  output logic           busy_o,
  output logic           done_o,
  x64e_res_if.source     res
);
  import x64e_pkg::*;

  seq_t            seq_q;
  logic [CntW-1:0] idx_q, idx_d;
  logic            busy_q, busy_d;
  logic [31:0]     pos_q, pos_d;
  logic [CntW-1:0] nxt;

  always_comb begin
    nxt      = idx_q + 4'd1;
    idx_d    = idx_q;
    busy_d   = busy_q;
    pos_d    = pos_q;
    done_o   = busy_q && res.ready && (nxt == seq_q.count);
    if (busy_q && res.ready) begin
      idx_d = nxt;
      pos_d = pos_q + 32'd1;
      if (done_o) busy_d = 1'b0;
    end
    if (load_i) begin
      idx_d  = '0;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      busy_q <= 1'b0;
      pos_q  <= '0;
    end else begin
      idx_q  <= idx_d;
      busy_q <= busy_d;
      pos_q  <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) seq_q <= seq_i;
  end

  assign busy_o                 = busy_q;
  assign res.valid              = busy_q;
  assign res.data.code_byte     = seq_q.bytes[idx_q];
  assign res.data.byte_position = pos_q;
  assign res.data.patch_site    = seq_q.marks[idx_q];
  assign res.data.last_byte     = (nxt == seq_q.count);
endmodule

>>> hw/rtl/x64_instruction_byte_encoder_unit.sv
// An accepted item is registered in req_q, encoded, and loaded into the emitter
// once it is idle or on its last byte; bytes then leave at one byte per cycle while
// res.ready is high. An item has 1 to 12 bytes; the next item is encoded meanwhile.
// Forms that emit no bytes are dropped without waiting and leave the position unchanged.
// Reset (rst_ni, async low) clears the valid flags and the byte position.
`timescale 1ns / 1ps
module x64_instruction_byte_encoder_unit (
  input logic       clk_i,
  input logic       rst_ni,
  x64e_req_if.sink  req,
  x64e_res_if.source res
);
  import x64e_pkg::*;

  req_t req_q;
  logic req_valid_q;
  seq_t seq;
  logic busy, done, load, take;

  x64e_encode u_enc (.req_i(req_q), .seq_o(seq));

  assign load      = req_valid_q && (seq.count != '0) && (!busy || done);
  assign take      = req_valid_q && ((seq.count == '0) || !busy || done);
  assign req.ready = !req_valid_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (req.ready) begin
      req_valid_q <= req.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.ready && req.valid) req_q <= req.data;
  end

  x64e_emit u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .seq_i  (seq),
    .load_i (load),
    .busy_o (busy),
    .done_o (done),
    .res    (res)
  );
endmodule

>>> bench/tb_x64_instruction_byte_encoder_unit.sv
`timescale 1ns / 1ps
module tb_x64_instruction_byte_encoder_unit;
  import x64e_pkg::*;

  class byte_stream_board;
    res_t        pending[$];
    logic [31:0] stream_pos;
    int          mismatches;
    logic [7:0]  enc_bytes[$];
    bit          enc_marks[$];

    function new();
      stream_pos = '0;
      mismatches = 0;
    endfunction

    function void emit(logic [7:0] b);
      enc_bytes.push_back(b);
      enc_marks.push_back(1'b0);
    endfunction

    function void emit32(logic [31:0] v);
      emit(v[7:0]); emit(v[15:8]); emit(v[23:16]); emit(v[31:24]);
    endfunction

    function void emit_rel32();
      int first;
      first = enc_bytes.size();
      emit32('0);
      enc_marks[first] = 1'b1;
    endfunction

    function bit fits_byte(logic [31:0] v);
      logic [31:0] t;
      t = v + 32'd128;
      return t < 32'd256;
    endfunction

    function logic [7:0] modrm(logic [7:0] mode, logic [3:0] r, logic [3:0] m);
      return mode | {2'b00, r[2:0], 3'b000} | {5'b0, m[2:0]};
    endfunction

    function logic [7:0] rex_w(logic [3:0] r, logic [3:0] b);
      return 8'h48 | (r >= 8 ? 8'h04 : 8'h00) | (b >= 8 ? 8'h01 : 8'h00);
    endfunction

    function void rex_b(logic [3:0] r);
      if (r >= 8) emit(8'h41);
    endfunction

    function void mem_operand(logic [3:0] r, logic [3:0] base, logic [31:0] disp);
      bit          sib;
      logic [7:0]  mode;
      sib = (base[2:0] == 3'd4);
      if (disp == 0 && base[2:0] != 3'd5) mode = 8'h00;
      else if (fits_byte(disp)) mode = 8'h40;
      else mode = 8'h80;
      emit(modrm(mode, r, sib ? 4'd4 : base));
      if (sib) emit(8'h24);
      if (mode == 8'h40) emit(disp[7:0]);
      else if (mode == 8'h80) emit32(disp);
    endfunction

    function void reg_reg(logic [7:0] opc, logic [3:0] r, logic [3:0] m);
      emit(rex_w(r, m)); emit(opc); emit(modrm(8'hC0, r, m));
    endfunction

    function void unary(logic [7:0] opc, logic [3:0] ext, logic [3:0] r);
      emit(rex_w(0, r)); emit(opc); emit(modrm(8'hC0, ext, r));
    endfunction

    function void alu_imm(logic [3:0] ext, logic [3:0] r, logic [31:0] imm);
      emit(rex_w(0, r));
      if (fits_byte(imm)) begin
        emit(8'h83); emit(modrm(8'hC0, ext, r)); emit(imm[7:0]);
      end else begin
        emit(8'h81); emit(modrm(8'hC0, ext, r)); emit32(imm);
      end
    endfunction

    function void note_request(req_t q);
      logic [3:0]  a, b;
      logic [31:0] d, i32;
      logic [2:0]  c;
      logic [7:0]  setc, jcc;
      res_t        r;
      a = q.first_reg; b = q.second_reg; d = q.displacement;
      i32 = q.immediate[31:0];
      c = (q.condition > 3'd5) ? 3'd5 : q.condition;
      case (c)
        3'd0: begin setc = 8'h9C; jcc = 8'h8C; end
        3'd1: begin setc = 8'h9F; jcc = 8'h8F; end
        3'd2: begin setc = 8'h94; jcc = 8'h84; end
        3'd3: begin setc = 8'h95; jcc = 8'h85; end
        3'd4: begin setc = 8'h9E; jcc = 8'h8E; end
        default: begin setc = 8'h9D; jcc = 8'h8D; end
      endcase
      enc_bytes.delete();
      enc_marks.delete();
      case (q.operation)
        OP_MOV_RI64: begin
          emit(rex_w(0, a)); emit(8'hB8 + a[2:0]);
          emit32(i32); emit32(q.immediate[63:32]);
        end
        OP_MOV_RI32: begin
          emit(rex_w(0, a)); emit(8'hC7); emit(modrm(8'hC0, 0, a)); emit32(i32);
        end
        OP_MOV_RR: reg_reg(8'h89, b, a);
        OP_MOV_RM: begin emit(rex_w(a, b)); emit(8'h8B); mem_operand(a, b, d); end
        OP_MOV_MR: begin emit(rex_w(a, b)); emit(8'h89); mem_operand(a, b, d); end
        OP_MOV_MI: begin
          emit(rex_w(0, b)); emit(8'hC7); mem_operand(0, b, d); emit32(i32);
        end
        OP_ADD_RR: reg_reg(8'h01, b, a);
        OP_ADD_RI: alu_imm(0, a, i32);
        OP_SUB_RR: reg_reg(8'h29, b, a);
        OP_SUB_RI: alu_imm(5, a, i32);
        OP_IMUL: begin
          emit(rex_w(a, b)); emit(8'h0F); emit(8'hAF); emit(modrm(8'hC0, a, b));
        end
        OP_IDIV: unary(8'hF7, 7, a);
        OP_CQO: begin emit(8'h48); emit(8'h99); end
        OP_NEG: unary(8'hF7, 3, a);
        OP_INC: unary(8'hFF, 0, a);
        OP_DEC: unary(8'hFF, 1, a);
        OP_CMP_RR: reg_reg(8'h39, b, a);
        OP_CMP_RI: alu_imm(7, a, i32);
        OP_CMP_MB: begin rex_b(b); emit(8'h80); mem_operand(7, b, d); emit(i32[7:0]); end
        OP_TEST: reg_reg(8'h85, b, a);
        OP_SETCC: begin rex_b(a); emit(8'h0F); emit(setc); emit(modrm(8'hC0, 0, a)); end
        OP_MOVZX: begin
          emit(rex_w(a, b)); emit(8'h0F); emit(8'hB6); emit(modrm(8'hC0, a, b));
        end
        OP_JMP_REL: begin emit(8'hE9); emit_rel32(); end
        OP_JMP_R: begin rex_b(a); emit(8'hFF); emit(modrm(8'hC0, 4, a)); end
        OP_JCC: begin emit(8'h0F); emit(jcc); emit_rel32(); end
        OP_CALL_R: begin rex_b(a); emit(8'hFF); emit(modrm(8'hC0, 2, a)); end
        OP_CALL_REL: begin emit(8'hE8); emit_rel32(); end
        OP_RET: emit(8'hC3);
        OP_PUSH: begin rex_b(a); emit(8'h50 + a[2:0]); end
        OP_POP: begin rex_b(a); emit(8'h58 + a[2:0]); end
        OP_AND: reg_reg(8'h21, b, a);
        OP_OR: reg_reg(8'h09, b, a);
        OP_XOR: reg_reg(8'h31, b, a);
        OP_NOT: unary(8'hF7, 2, a);
        OP_LEA: begin emit(rex_w(a, b)); emit(8'h8D); mem_operand(a, b, d); end
        OP_NOP: emit(8'h90);
        default: ;
      endcase
      for (int k = 0; k < enc_bytes.size(); k++) begin
        r.code_byte = enc_bytes[k];
        r.byte_position = stream_pos;
        r.patch_site = enc_marks[k];
        r.last_byte = (k + 1 == enc_bytes.size());
        pending.push_back(r);
        stream_pos++;
      end
    endfunction

    function void check_byte(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected byte: %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp byte %h pos %0d patch %b last %b, got %h %0d %b %b",
                   want.code_byte, want.byte_position, want.patch_site, want.last_byte,
                   got.code_byte, got.byte_position, got.patch_site, got.last_byte);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  x64e_req_if req();
  x64e_res_if res();

  x64_instruction_byte_encoder_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req.sink),
    .res   (res.source)
  );

  byte_stream_board board;
  int send_idle_pct;
  int recv_idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && res.valid && res.ready) board.check_byte(res.data);
    if (rst_ni && req.valid && req.ready) board.note_request(req.data);
  end

  always @(posedge clk_i) begin
    if (!rst_ni) res.ready <= 1'b0;
    else res.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_request(req_t q);
    if ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.data <= q;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
  endtask

  function automatic req_t random_request();
    req_t q;
    q.operation = ($urandom_range(19) == 0) ? 6'($urandom_range(63)) :
                  6'($urandom_range(35));
    q.first_reg = 4'($urandom);
    q.second_reg = 4'($urandom);
    case ($urandom_range(3))
      0: q.displacement = '0;
      1: q.displacement = 32'($signed($urandom_range(255)) - 128);
      default: q.displacement = $urandom;
    endcase
    case ($urandom_range(2))
      0: q.immediate = 64'($signed($urandom_range(255)) - 128);
      default: q.immediate = {$urandom, $urandom};
    endcase
    q.condition = 3'($urandom);
    return q;
  endfunction

  function automatic req_t make_req(op_e op, logic [3:0] a, logic [3:0] b,
                                    logic [31:0] d, logic [63:0] i, logic [2:0] c);
    req_t q;
    q.operation = op; q.first_reg = a; q.second_reg = b;
    q.displacement = d; q.immediate = i; q.condition = c;
    return q;
  endfunction

  initial begin
    int waited;
    board = new();
    send_idle_pct = 20;
    recv_idle_pct = 69;
    rst_ni = 1'b0;
    req.valid = 1'b0;
    req.data = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int op = 0; op < 36; op += 2)
      send_request(make_req(op_e'(op), 4'(op % 16), 4'(15 - op % 16),
                            32'h0, 64'h7FFF_FFFF_FFFF_FFFF, 3'(op % 8)));
    send_request(make_req(OP_MOV_RM, 4'd15, 4'd12, 32'h0, '0, '0));
    send_request(make_req(OP_MOV_MR, 4'd8, 4'd13, 32'h0, '0, '0));
    send_request(make_req(OP_LEA, 4'd0, 4'd4, 32'h8000_0000, '0, '0));
    send_request(make_req(OP_MOV_MI, 4'd0, 4'd5, 32'h7F, 64'h8000_0000_0000_0000, '0));
    send_request(make_req(OP_CMP_MB, 4'd0, 4'd12, 32'hFFFF_FF80, 64'hFF, '0));
    send_request(make_req(OP_SETCC, 4'd6, 4'd0, '0, '0, 3'd7));
    send_request(make_req(OP_JCC, 4'd0, 4'd0, '0, '0, 3'd6));
    send_request(make_req(OP_ADD_RI, 4'd9, 4'd0, '0, 64'hFFFF_FFFF_FFFF_FF80, '0));
    send_request(make_req(OP_SUB_RI, 4'd1, 4'd0, '0, 64'h80, '0));
    send_request(make_req(op_e'(6'd63), 4'd0, 4'd0, '0, '0, '0));
    for (int i = 0; i < 54; i++) begin
      if (i == 18) begin send_idle_pct = 69; recv_idle_pct = 20; end
      if (i == 36) begin send_idle_pct = 0; recv_idle_pct = 0; end
      send_request(random_request());
    end
    for (int op = 1; op < 36; op += 2)
      send_request(make_req(op_e'(op), 4'(op % 16), 4'(op % 16), 32'hFFFF_FFFF,
                            64'hFFFF_FFFF_FFFF_FFFF, 3'(op % 8)));
    req.valid <= 1'b0;
    waited = 0;
    while (board.pending.size() != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (20) @(posedge clk_i);
    if (board.pending.size() == 0 && board.mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

>>> x64_instruction_byte_encoder_unit.f
hw/rtl/x64e_pkg.sv
hw/rtl/x64e_req_if.sv
hw/rtl/x64e_res_if.sv
hw/rtl/x64e_encode.sv
hw/rtl/x64e_emit.sv
hw/rtl/x64_instruction_byte_encoder_unit.sv
bench/tb_x64_instruction_byte_encoder_unit.sv
